@@ design/gmrs_pkg.sv @@
package gmrs_pkg;

    // Height digits and the value that stands in for a neighbor outside the grid.
    localparam logic [3:0] OUTSIDE_HEIGHT = 4'd10;
    localparam logic [3:0] HEIGHT_MAX     = 4'd9;

    // Row width after reset.
    localparam logic [7:0] ROW_WIDTH_RESET = 8'd100;

    // One line store word holds the older row digit above the previous row digit.
    localparam int unsigned LINE_BITS = 8;

    // Positions in the mask of judgments that one item causes, in emission order.
    localparam int unsigned JUDGE_UPPER = 0;  // cell directly above the new cell
    localparam int unsigned JUDGE_LEFT  = 1;  // final row: cell left of the new cell
    localparam int unsigned JUDGE_SELF  = 2;  // final row, last column: the new cell
    localparam int unsigned JUDGE_COUNT = 3;

    typedef logic [3:0]             height_t;
    typedef logic [15:0]            row_idx_t;
    typedef logic [JUDGE_COUNT-1:0] judge_mask_t;

    // Item context handed from the scan stage to the judging stage.
    typedef struct packed {
        row_idx_t   row;
        logic [1:0] rows_done;
        logic       final_row;
        logic       last_col;
        height_t    height;
    } issue_t;

    // A cell is low when it is strictly below all four neighbors.
    function automatic logic below_all(
        input height_t v,
        input height_t up,
        input height_t down,
        input height_t left,
        input height_t right
    );
        below_all = (v < up) && (v < down) && (v < left) && (v < right);
    endfunction

endpackage

@@ design/gmrs_line_ram.sv @@
module gmrs_line_ram #(
    parameter int unsigned MAX_WIDTH = 128
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr_a,
    input  logic [AW-1:0]                      rd_addr_b,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic [gmrs_pkg::LINE_BITS-1:0]     wr_data,
    output logic [gmrs_pkg::LINE_BITS-1:0]     q_a,
    output logic [gmrs_pkg::LINE_BITS-1:0]     q_b
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [gmrs_pkg::LINE_BITS-1:0] mem [MAX_WIDTH];
    logic [gmrs_pkg::LINE_BITS-1:0] ram_a_reg;
    logic [gmrs_pkg::LINE_BITS-1:0] ram_b_reg;
    logic [gmrs_pkg::LINE_BITS-1:0] bypass_reg;
    logic                           hit_a_reg;
    logic                           hit_b_reg;

    // Line store: one write port, two read ports, read data registered.
    // A read that meets a write to the same entry in the same cycle takes the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_a_reg  <= mem[rd_addr_a];
            ram_b_reg  <= mem[rd_addr_b];
            hit_a_reg  <= wr_en && (wr_addr == rd_addr_a);
            hit_b_reg  <= wr_en && (wr_addr == rd_addr_b);
            bypass_reg <= wr_data;
        end
    end

    assign q_a = hit_a_reg ? bypass_reg : ram_a_reg;
    assign q_b = hit_b_reg ? bypass_reg : ram_b_reg;

endmodule

@@ design/gmrs_scan.sv @@
module gmrs_scan #(
    parameter int unsigned MAX_WIDTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               row_width,
    input  logic                     accept,
    input  gmrs_pkg::height_t        item_height,
    input  logic                     item_final,
    output gmrs_pkg::issue_t         issue,
    output gmrs_pkg::judge_mask_t    pending,
    output logic [AW-1:0]            column
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

    logic [AW-1:0]          col_reg;
    logic [AW-1:0]          col_next;
    gmrs_pkg::row_idx_t     row_reg;
    gmrs_pkg::row_idx_t     row_next;
    logic [1:0]             rows_done_reg;
    logic [1:0]             rows_done_next;
    logic                   final_reg;
    logic                   final_next;

    logic [WW-1:0]          width_eff;
    logic [WW-1:0]          width_last;
    logic [AW-1:0]          col_cur;
    logic                   last_col;
    logic                   final_now;
    gmrs_pkg::height_t      height_clamped;

    // Effective row width: zero acts as one, anything past the store depth as its depth.
    always_comb
    begin
        if (row_width == 8'd0)
        begin
            width_eff = WW'(1);
        end
        else if (32'(row_width) > MAX_WIDTH)
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(row_width);
        end
        width_last = width_eff - WW'(1);
    end

    // Current column, pinned to the last column if the width shrank mid-row.
    always_comb
    begin
        if (WW'(col_reg) >= width_last)
        begin
            col_cur = AW'(width_last);
        end
        else
        begin
            col_cur = col_reg;
        end
        last_col       = (WW'(col_cur) == width_last);
        final_now      = (col_cur == '0) ? item_final : final_reg;
        height_clamped = (item_height > gmrs_pkg::HEIGHT_MAX) ? gmrs_pkg::HEIGHT_MAX
                                                              : item_height;
    end

    // Context of the item being accepted and the judgments it causes.
    always_comb
    begin
        issue.row       = row_reg;
        issue.rows_done = rows_done_reg;
        issue.final_row = final_now;
        issue.last_col  = last_col;
        issue.height    = height_clamped;
        pending[gmrs_pkg::JUDGE_UPPER] = (rows_done_reg != 2'd0);
        pending[gmrs_pkg::JUDGE_LEFT]  = final_now && (col_cur != '0);
        pending[gmrs_pkg::JUDGE_SELF]  = final_now && last_col;
        column = col_cur;
    end

    // Raster position: advance per item, wrap per row, restart after the final row.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        rows_done_next = rows_done_reg;
        final_next     = final_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next   = '0;
                final_next = 1'b0;
                if (final_now)
                begin
                    row_next       = '0;
                    rows_done_next = 2'd0;
                end
                else
                begin
                    row_next       = row_reg + 16'd1;
                    rows_done_next = (rows_done_reg == 2'd2) ? 2'd2 : rows_done_reg + 2'd1;
                end
            end
            else
            begin
                col_next   = col_cur + AW'(1);
                final_next = final_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            rows_done_reg <= 2'd0;
            final_reg     <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            rows_done_reg <= rows_done_next;
            final_reg     <= final_next;
        end
    end

    // The end of the final row returns the grid position to the origin.
    a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col && final_now |=> (row_reg == '0) && (rows_done_reg == 2'd0))
        else $error("grid position not cleared after final row");

endmodule

@@ design/gmrs_emit.sv @@
module gmrs_emit #(
    parameter int unsigned MAX_WIDTH = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  gmrs_pkg::issue_t                 issue_in,
    input  gmrs_pkg::judge_mask_t            pending_in,
    input  logic [AW-1:0]                    column_in,
    input  logic [gmrs_pkg::LINE_BITS-1:0]   line_cur,
    input  logic [gmrs_pkg::LINE_BITS-1:0]   line_right,
    output logic                             ready,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [gmrs_pkg::LINE_BITS-1:0]   wr_data,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [15:0]                      cell_row,
    output logic [6:0]                       cell_column,
    output logic [3:0]                       cell_height,
    output logic                             is_low,
    output logic [3:0]                       risk,
    output logic [31:0]                      risk_total,
    output logic                             run_end,
    output logic                             grid_done
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                    b_valid_reg;
    logic                    b_valid_next;
    gmrs_pkg::issue_t        issue_reg;
    logic [AW-1:0]           col_reg;
    gmrs_pkg::judge_mask_t   pending_reg;
    gmrs_pkg::judge_mask_t   pending_next;
    gmrs_pkg::height_t       upper_left_reg;
    gmrs_pkg::height_t       upper_left_next;
    gmrs_pkg::height_t       left_reg;
    gmrs_pkg::height_t       left_next;
    gmrs_pkg::height_t       left2_reg;
    gmrs_pkg::height_t       left2_next;
    logic [31:0]             acc_reg;
    logic [31:0]             acc_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [15:0]             cell_row_reg;
    logic [6:0]              cell_column_reg;
    logic [3:0]              cell_height_reg;
    logic                    is_low_reg;
    logic [3:0]              risk_reg;
    logic [31:0]             risk_total_reg;
    logic                    run_end_reg;
    logic                    grid_done_reg;

    gmrs_pkg::height_t       prev_here;
    gmrs_pkg::height_t       older_here;
    gmrs_pkg::height_t       prev_right;
    gmrs_pkg::judge_mask_t   lowest;
    gmrs_pkg::judge_mask_t   pending_after;
    logic                    out_load;
    logic                    b_done;
    logic                    grid_end;

    gmrs_pkg::height_t       up_v;
    gmrs_pkg::height_t       up_up;
    gmrs_pkg::height_t       up_left;
    gmrs_pkg::height_t       up_right;
    gmrs_pkg::height_t       lf_up;
    gmrs_pkg::height_t       lf_left;
    gmrs_pkg::height_t       sf_up;
    gmrs_pkg::height_t       sf_left;
    logic                    up_low;
    logic                    lf_low;
    logic                    sf_low;

    gmrs_pkg::height_t       sel_v;
    logic                    sel_low;
    gmrs_pkg::row_idx_t      sel_row;
    logic [AW-1:0]           sel_col;
    logic [4:0]              sel_risk;
    logic [32:0]             acc_sum;
    logic [31:0]             acc_sat;

    // Line store words: older row digit in the upper half, previous row digit below.
    assign prev_here  = line_cur[3:0];
    assign older_here = line_cur[7:4];
    assign prev_right = line_right[3:0];

    // Neighbors of the three candidate cells.
    always_comb
    begin
        // Cell above the new one: its down neighbor is the new digit.
        up_v     = prev_here;
        up_up    = (issue_reg.rows_done == 2'd2) ? older_here : gmrs_pkg::OUTSIDE_HEIGHT;
        up_left  = (col_reg != '0) ? upper_left_reg : gmrs_pkg::OUTSIDE_HEIGHT;
        up_right = !issue_reg.last_col ? prev_right : gmrs_pkg::OUTSIDE_HEIGHT;
        up_low   = gmrs_pkg::below_all(up_v, up_up, issue_reg.height, up_left, up_right);

        // Final row, cell left of the new one: nothing below it.
        lf_up    = (issue_reg.rows_done != 2'd0) ? upper_left_reg : gmrs_pkg::OUTSIDE_HEIGHT;
        lf_left  = (32'(col_reg) >= 2) ? left2_reg : gmrs_pkg::OUTSIDE_HEIGHT;
        lf_low   = gmrs_pkg::below_all(left_reg, lf_up, gmrs_pkg::OUTSIDE_HEIGHT,
                                       lf_left, issue_reg.height);

        // Final row, last column: the new cell itself.
        sf_up    = (issue_reg.rows_done != 2'd0) ? prev_here : gmrs_pkg::OUTSIDE_HEIGHT;
        sf_left  = (col_reg != '0) ? left_reg : gmrs_pkg::OUTSIDE_HEIGHT;
        sf_low   = gmrs_pkg::below_all(issue_reg.height, sf_up, gmrs_pkg::OUTSIDE_HEIGHT,
                                       sf_left, gmrs_pkg::OUTSIDE_HEIGHT);
    end

    // Pick the next judgment in emission order.
    always_comb
    begin
        lowest        = pending_reg & (~pending_reg + gmrs_pkg::judge_mask_t'(1));
        pending_after = pending_reg & ~lowest;
        if (pending_reg[gmrs_pkg::JUDGE_UPPER])
        begin
            sel_v   = up_v;
            sel_low = up_low;
            sel_row = issue_reg.row - 16'd1;
            sel_col = col_reg;
        end
        else if (pending_reg[gmrs_pkg::JUDGE_LEFT])
        begin
            sel_v   = left_reg;
            sel_low = lf_low;
            sel_row = issue_reg.row;
            sel_col = col_reg - AW'(1);
        end
        else
        begin
            sel_v   = issue_reg.height;
            sel_low = sf_low;
            sel_row = issue_reg.row;
            sel_col = col_reg;
        end
        sel_risk = sel_low ? ({1'b0, sel_v} + 5'd1) : 5'd0;
        acc_sum  = {1'b0, acc_reg} + 33'(sel_risk);
        acc_sat  = acc_sum[32] ? '1 : acc_sum[31:0];
    end

    // Handshake: one result a cycle into the output register unless out_stall
    // holds it; the item retires with its last result, or at once with none.
    always_comb
    begin
        grid_end = issue_reg.final_row && issue_reg.last_col;
        out_load = b_valid_reg && (pending_reg != '0) && (!out_valid_reg || !out_stall);
        b_done   = b_valid_reg && ((pending_reg == '0) || (out_load && (pending_after == '0)));
        ready    = !b_valid_reg || b_done;
    end

    // Next state of the judging stage.
    always_comb
    begin
        b_valid_next    = b_valid_reg;
        pending_next    = pending_reg;
        upper_left_next = upper_left_reg;
        left_next       = left_reg;
        left2_next      = left2_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            pending_next   = pending_after;
            acc_next       = (grid_end && (pending_after == '0)) ? 32'd0 : acc_sat;
        end
        if (b_done)
        begin
            b_valid_next = 1'b0;
            left2_next   = left_reg;
            if (grid_end)
            begin
                upper_left_next = '0;
                left_next       = '0;
            end
            else
            begin
                upper_left_next = prev_here;
                left_next       = issue_reg.height;
            end
        end
        if (accept)
        begin
            b_valid_next = 1'b1;
            pending_next = pending_in;
        end
    end

    // Write back both rows of the retiring column.
    assign wr_en   = b_done;
    assign wr_addr = col_reg;
    assign wr_data = {prev_here, issue_reg.height};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg    <= 1'b0;
            pending_reg    <= '0;
            upper_left_reg <= '0;
            left_reg       <= '0;
            left2_reg      <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg    <= b_valid_next;
            pending_reg    <= pending_next;
            upper_left_reg <= upper_left_next;
            left_reg       <= left_next;
            left2_reg      <= left2_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item context and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            issue_reg <= issue_in;
            col_reg   <= column_in;
        end
        if (out_load)
        begin
            cell_row_reg    <= sel_row;
            cell_column_reg <= 7'(sel_col);
            cell_height_reg <= sel_v;
            is_low_reg      <= sel_low;
            risk_reg        <= sel_risk[3:0];
            risk_total_reg  <= acc_sat;
            run_end_reg     <= (pending_after == '0);
            grid_done_reg   <= lowest[gmrs_pkg::JUDGE_SELF];
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_row    = cell_row_reg;
    assign cell_column = cell_column_reg;
    assign cell_height = cell_height_reg;
    assign is_low      = is_low_reg;
    assign risk        = risk_reg;
    assign risk_total  = risk_total_reg;
    assign run_end     = run_end_reg;
    assign grid_done   = grid_done_reg;

    // The last-cell judgment exists only for the last column of the final row.
    a_self_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && pending_reg[gmrs_pkg::JUDGE_SELF]
            |-> issue_reg.final_row && issue_reg.last_col)
        else $error("last-cell judgment pending outside the grid's last cell");

    // The grid's final result closes its item.
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && grid_done_reg |-> run_end_reg)
        else $error("grid done without run end");

    // The risk sum restarts after the grid's final result.
    a_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && lowest[gmrs_pkg::JUDGE_SELF] |=> (acc_reg == '0))
        else $error("risk sum not cleared at grid end");

    // A cell that is not low carries no risk.
    a_risk_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_low_reg |-> (risk_reg == 4'd0))
        else $error("risk on a cell that is not low");

endmodule

@@ design/grid_local_minimum_risk_sum.sv @@
// Four-neighbor low point finder over a height grid streamed in raster order,
// one digit per item, with final_row read on the first cell of a row to mark
// the grid's last row. Every cell is judged once and gets one result with its
// position, height, low flag, risk and the grid's saturating risk sum. The
// cell above each new item is judged as that item arrives, so results trail
// the input by a row. Items are accepted one per cycle unless out_stall or an
// item's further results hold the judging stage; results pass the judging
// stage and leave through one output register at one per cycle while
// out_stall is low. Outside the final row an item gives one result, none in
// the first row; a final-row item adds one for the cell to its left past the
// first column and one for itself at the last column; these stall the input.
// Two rows of history sit in one line store of MAX_WIDTH words, read at the
// current and next column and written back as an item retires; there is no
// clearing pass after reset. Write row_width only while no item is in flight.
module grid_local_minimum_risk_sum #(
    parameter int unsigned MAX_WIDTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  height,
    input  logic        final_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_row,
    output logic [6:0]  cell_column,
    output logic [3:0]  cell_height,
    output logic        is_low,
    output logic [3:0]  risk,
    output logic [31:0] risk_total,
    output logic        run_end,
    output logic        grid_done
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [7:0]                       row_width_reg;
    logic [7:0]                       row_width_next;
    logic                             accept;
    logic                             ready;
    gmrs_pkg::issue_t                 issue;
    gmrs_pkg::judge_mask_t            pending;
    logic [AW-1:0]                    column;
    logic [AW-1:0]                    column_right;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [gmrs_pkg::LINE_BITS-1:0]   wr_data;
    logic [gmrs_pkg::LINE_BITS-1:0]   line_cur;
    logic [gmrs_pkg::LINE_BITS-1:0]   line_right;

    // Row width register.
    assign row_width_next = cfg_wr_en ? cfg_wr_data : row_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= gmrs_pkg::ROW_WIDTH_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
        end
    end

    // Input handshake.
    assign in_stall     = !ready;
    assign accept       = in_valid && ready;
    assign column_right = column + AW'(1);

    gmrs_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_width   (row_width_reg),
        .accept      (accept),
        .item_height (height),
        .item_final  (final_row),
        .issue       (issue),
        .pending     (pending),
        .column      (column)
    );

    gmrs_line_ram #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (column),
        .rd_addr_b (column_right),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_a       (line_cur),
        .q_b       (line_right)
    );

    gmrs_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .issue_in    (issue),
        .pending_in  (pending),
        .column_in   (column),
        .line_cur    (line_cur),
        .line_right  (line_right),
        .ready       (ready),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .cell_height (cell_height),
        .is_low      (is_low),
        .risk        (risk),
        .risk_total  (risk_total),
        .run_end     (run_end),
        .grid_done   (grid_done)
    );

endmodule

@@ test/testbench.sv @@
module testbench;
    import gmrs_pkg::*;

    localparam int unsigned LINE_DEPTH     = 128;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_CELLS   = 270;
    localparam int unsigned WRAP_ROWS      = 65538;

    // One judged cell, laid out in the order of the result ports.
    typedef struct packed {
        row_idx_t    row;
        logic [6:0]  column;
        height_t     height;
        logic        low;
        logic [3:0]  risk;
        logic [31:0] total;
        logic        run_end;
        logic        grid_done;
    } cell_verdict_t;

    // Tracks the grid state of the block and the verdicts it still owes.
    class verdict_book;
        height_t       recent_row [LINE_DEPTH];
        height_t       earlier_row [LINE_DEPTH];
        height_t       upper_left;
        height_t       left_cell;
        int unsigned   column;
        row_idx_t      row;
        logic [31:0]   risk_sum;
        int unsigned   rows_seen;
        logic          final_latch;
        logic [7:0]    width_reg;
        cell_verdict_t due [$];
        int            errors;
        int            cells;
        int            checked;
        int            lows;

        function new();
            foreach (recent_row[i]) begin
                recent_row[i]  = '0;
                earlier_row[i] = '0;
            end
            upper_left  = '0;
            left_cell   = '0;
            column      = 0;
            row         = '0;
            risk_sum    = '0;
            rows_seen   = 0;
            final_latch = 1'b0;
            width_reg   = ROW_WIDTH_RESET;
            errors      = 0;
            cells       = 0;
            checked     = 0;
            lows        = 0;
        endfunction

        function void set_width(input logic [7:0] value);
            width_reg = value;
        endfunction

        // Width as the block uses it: zero acts as one, too wide acts as the store depth.
        function int unsigned span();
            if (width_reg == 8'd0)
                return 1;
            if (width_reg > LINE_DEPTH)
                return LINE_DEPTH;
            return width_reg;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Judges one cell against its four neighbors and advances the risk sum.
        function cell_verdict_t rate(input row_idx_t r, input int unsigned c, input height_t v,
                                     input height_t up, input height_t down,
                                     input height_t left, input height_t right);
            cell_verdict_t res;
            logic          low;
            logic [3:0]    gain;
            low  = (v < up) && (v < down) && (v < left) && (v < right);
            gain = low ? v + 4'd1 : 4'd0;
            if (risk_sum > 32'hFFFF_FFFF - 32'(gain))
                risk_sum = 32'hFFFF_FFFF;
            else
                risk_sum = risk_sum + 32'(gain);
            res        = '0;
            res.row    = r;
            res.column = 7'(c);
            res.height = v;
            res.low    = low;
            res.risk   = gain;
            res.total  = risk_sum;
            return res;
        endfunction

        // Works out the verdicts that one accepted item causes and queues them.
        function void note_cell(input logic [3:0] h_in, input logic fin);
            cell_verdict_t found [3];
            int            n;
            int unsigned   w;
            int unsigned   c;
            height_t       h;
            height_t       prev;
            height_t       up;
            height_t       left;
            height_t       right;
            n = 0;
            cells++;
            w = span();
            h = (h_in > HEIGHT_MAX) ? HEIGHT_MAX : h_in;
            c = column;
            if (c >= w)
                c = w - 1;
            if (c == 0)
                final_latch = fin;
            prev = recent_row[c];

            // The cell one row up is complete now that the cell below it is known.
            if (rows_seen >= 1) begin
                up    = (rows_seen >= 2) ? earlier_row[c] : OUTSIDE_HEIGHT;
                left  = (c > 0) ? upper_left : OUTSIDE_HEIGHT;
                right = (c + 1 < w) ? recent_row[c + 1] : OUTSIDE_HEIGHT;
                found[n] = rate(row - 16'd1, c, prev, up, h, left, right);
                n++;
            end
            upper_left     = prev;
            earlier_row[c] = prev;
            recent_row[c]  = h;

            // In the last row nothing lies below, so cells are judged as soon as
            // their right neighbor arrives, and the last one at once.
            if (final_latch) begin
                if (c > 0) begin
                    up   = (rows_seen >= 1) ? earlier_row[c - 1] : OUTSIDE_HEIGHT;
                    left = (c >= 2) ? recent_row[c - 2] : OUTSIDE_HEIGHT;
                    found[n] = rate(row, c - 1, left_cell, up, OUTSIDE_HEIGHT, left, h);
                    n++;
                end
                if (c + 1 == w) begin
                    up   = (rows_seen >= 1) ? prev : OUTSIDE_HEIGHT;
                    left = (c > 0) ? left_cell : OUTSIDE_HEIGHT;
                    found[n] = rate(row, c, h, up, OUTSIDE_HEIGHT, left, OUTSIDE_HEIGHT);
                    found[n].grid_done = 1'b1;
                    n++;
                end
            end
            left_cell = h;
            if (n > 0)
                found[n - 1].run_end = 1'b1;
            for (int i = 0; i < n; i++)
                due.push_back(found[i]);

            // Step the raster position; the end of the final row starts a new grid.
            if (c + 1 == w) begin
                column = 0;
                if (final_latch) begin
                    row         = '0;
                    rows_seen   = 0;
                    risk_sum    = '0;
                    upper_left  = '0;
                    left_cell   = '0;
                    final_latch = 1'b0;
                end else begin
                    row = row + 16'd1;
                    if (rows_seen < 2)
                        rows_seen++;
                end
            end else begin
                column = c + 1;
            end
        endfunction

        function void match(input string name, input logic [31:0] want, input logic [31:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // Compares one result from the block with the oldest verdict owed.
        function void check_result(input cell_verdict_t got);
            cell_verdict_t want;
            if (due.size() == 0) begin
                errors++;
                $error("result for row %0d column %0d with no cell waiting", got.row, got.column);
                return;
            end
            want = due.pop_front();
            checked++;
            if (want.low)
                lows++;
            match("cell_row", 32'(want.row), 32'(got.row));
            match("cell_column", 32'(want.column), 32'(got.column));
            match("cell_height", 32'(want.height), 32'(got.height));
            match("is_low", 32'(want.low), 32'(got.low));
            match("risk", 32'(want.risk), 32'(got.risk));
            match("risk_total", want.total, got.total);
            match("run_end", 32'(want.run_end), 32'(got.run_end));
            match("grid_done", 32'(want.grid_done), 32'(got.grid_done));
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [3:0]  height      = 4'd0;
    logic        final_row   = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] cell_row;
    logic [6:0]  cell_column;
    logic [3:0]  cell_height;
    logic        is_low;
    logic [3:0]  risk;
    logic [31:0] risk_total;
    logic        run_end;
    logic        grid_done;

    cell_verdict_t seen;
    verdict_book   book = new();
    bit            calm = 1'b0;
    bit            gappy = 1'b1;
    int unsigned   width_writes = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   stall_run = 0;
    int unsigned   open_run = 0;

    always #2 clk = ~clk;

    grid_local_minimum_risk_sum #(
        .MAX_WIDTH(LINE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .height(height),
        .final_row(final_row),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cell_row(cell_row),
        .cell_column(cell_column),
        .cell_height(cell_height),
        .is_low(is_low),
        .risk(risk),
        .risk_total(risk_total),
        .run_end(run_end),
        .grid_done(grid_done)
    );

    assign seen = {cell_row, cell_column, cell_height, is_low, risk, risk_total,
                   run_end, grid_done};

    // Check every result item the block hands over.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(seen);
    end

    // Stall the result side in random bursts, with open stretches between them.
    always @(posedge clk)
    begin
        if (calm || !rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end else if (open_run > 0) begin
            out_stall <= 1'b0;
            open_run  <= open_run - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_run <= $urandom_range(1, 16);
        end else begin
            open_run <= $urandom_range(1, 40);
        end
    end

    // End the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly digits, now and then a value above nine.
    function automatic logic [3:0] pick_height();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    // Wait until every owed result has come and the block has had time to settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [7:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.set_width(value);
        width_writes++;
    endtask

    // Offer one cell, after a random gap now and then, and hold it until taken.
    task automatic send_cell(input logic [3:0] h, input logic fin);
        int unsigned pause;
        if (!calm && gappy && $urandom_range(0, 4) == 0) begin
            pause = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid  <= 1'b1;
        height    <= h;
        final_row <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_cell(h, fin);
    endtask

    // Stream one grid; the flag on cells after the first of a row is noise.
    // When shrink_ok is set, now and then the width shrinks in the middle of a row.
    task automatic run_grid(input int unsigned rows, input bit shrink_ok);
        logic fin;
        for (int r = 0; r < rows; r++) begin
            do begin
                if (book.column == 0)
                    fin = (r == rows - 1);
                else
                    fin = 1'($urandom_range(0, 1));
                if (shrink_ok && book.column > 0 && book.span() > 1
                    && $urandom_range(0, 30) == 0)
                    write_width(8'($urandom_range(1, book.span() - 1)));
                send_cell(pick_height(), fin);
            end while (book.column != 0);
        end
    endtask

    initial
    begin
        int unsigned base;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width zero acts as a single column: a three-row grid of one cell each.
        write_width(8'd0);
        send_cell(4'd0, 1'b0);
        send_cell(4'd15, 1'b0);
        send_cell(4'd5, 1'b1);

        // A grid that is only its final row.
        write_width(8'd3);
        send_cell(4'd9, 1'b1);
        send_cell(4'd0, 1'b0);
        send_cell(4'd9, 1'b1);

        // Three rows with a low point in the middle; late flags are ignored.
        send_cell(4'd2, 1'b0);
        send_cell(4'd1, 1'b1);
        send_cell(4'd2, 1'b1);
        send_cell(4'd1, 1'b0);
        send_cell(4'd0, 1'b1);
        send_cell(4'd1, 1'b0);
        send_cell(4'd3, 1'b1);
        send_cell(4'd2, 1'b0);
        send_cell(4'd3, 1'b0);

        // Width shrinks past the current column in the middle of the second row.
        write_width(8'd4);
        send_cell(4'd5, 1'b0);
        send_cell(4'd7, 1'b0);
        send_cell(4'd4, 1'b0);
        send_cell(4'd8, 1'b0);
        send_cell(4'd6, 1'b0);
        send_cell(4'd3, 1'b0);
        write_width(8'd2);
        send_cell(4'd1, 1'b0);
        send_cell(4'd9, 1'b1);
        send_cell(4'd0, 1'b0);

        // Widest rows: a width above the store depth, then the full depth.
        write_width(8'd255);
        run_grid(1, 1'b0);
        write_width(8'd128);
        run_grid(2, 1'b0);

        // Random grids, mostly narrow and short.
        base = book.cells;
        while (book.cells - base < RANDOM_CELLS) begin
            gappy = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_width(8'd0);
                    1, 2:    write_width(8'($urandom_range(9, 24)));
                    default: write_width(8'($urandom_range(1, 8)));
                endcase
            end
            run_grid($urandom_range(1, 5), 1'b1);
        end

        // One-column grid with enough rows to carry the row index past its top.
        calm = 1'b1;
        write_width(8'd1);
        repeat (WRAP_ROWS) send_cell(pick_height(), 1'b0);
        send_cell(pick_height(), 1'b1);

        drain();
        $display("summary: %0d cells in, %0d results checked, %0d low points, %0d width writes",
                 book.cells, book.checked, book.lows, width_writes);
        $display("summary: widths 0 to 255, mid-row shrinks, single-row grids, row index wrap");
        if (book.errors == 0 && book.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
